### hw/rtl/cfq_pkg.sv
// Shared codes, constants and control/status types for the circular FIFO queue.
`timescale 1ns / 1ps

package cfq_pkg;

    localparam int DEPTH_DEFAULT = 8;
    localparam int WORD_W        = 32;
    localparam int OP_W          = 2;
    localparam int STATUS_W      = 2;

    localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE  = 2'd1;
    localparam logic [OP_W-1:0] OP_DISPLAY = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic                wr_en;       // store value at tail, advance tail, count up
        logic                pop;         // advance head, count down
        logic                scan_start;  // read head entry, set scan pointer past head, clear scan count
        logic                scan_step;   // read next scanned entry
        logic                out_load;    // load the output register
        logic                out_use_mem; // output data from store read
        logic [STATUS_W-1:0] out_status;
        logic                out_last;
    } cfq_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic empty;
        logic full;
        logic last_entry;  // scan sits on the newest held entry
        logic out_valid;
    } cfq_sts_t;

endpackage

### hw/rtl/cfq_datapath.sv
// Datapath: entry store, head/tail pointers, occupancy, scan pointer and output register.
`timescale 1ns / 1ps

module cfq_datapath #(
    parameter int DEPTH = cfq_pkg::DEPTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  cfq_pkg::cfq_cmd_t                   cmd,
    input  logic signed [cfq_pkg::WORD_W-1:0]   value,
    input  logic                                out_stall,
    output cfq_pkg::cfq_sts_t                   sts,
    output logic                                out_valid,
    output logic [cfq_pkg::STATUS_W-1:0]        status,
    output logic signed [cfq_pkg::WORD_W-1:0]   data,
    output logic                                last
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
    localparam logic [OCC_W-1:0] OCC_MAX = OCC_W'(DEPTH);

    logic [cfq_pkg::WORD_W-1:0] mem [DEPTH];

    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [OCC_W-1:0] occ_reg, occ_next;
    logic [PTR_W-1:0] scan_ptr_reg, scan_ptr_next;
    logic [OCC_W-1:0] scan_cnt_reg, scan_cnt_next;
    logic [PTR_W-1:0] rd_addr;
    logic             rd_en;
    logic [cfq_pkg::WORD_W-1:0] rd_data_reg;

    logic                         out_valid_reg;
    logic [cfq_pkg::STATUS_W-1:0] out_status_reg;
    logic [cfq_pkg::WORD_W-1:0]   out_data_reg;
    logic                         out_last_reg;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_MAX) ? '0 : p + PTR_W'(1);
    endfunction

    assign rd_en   = cmd.scan_start | cmd.scan_step;
    assign rd_addr = cmd.scan_start ? head_reg : scan_ptr_reg;

    always_comb
    begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        occ_next      = occ_reg;
        scan_ptr_next = scan_ptr_reg;
        scan_cnt_next = scan_cnt_reg;
        if (cmd.wr_en)
        begin
            tail_next = wrap_inc(tail_reg);
            occ_next  = occ_reg + OCC_W'(1);
        end
        if (cmd.pop)
        begin
            head_next = wrap_inc(head_reg);
            occ_next  = occ_reg - OCC_W'(1);
        end
        if (cmd.scan_start)
        begin
            scan_ptr_next = wrap_inc(head_reg);
            scan_cnt_next = '0;
        end
        else if (cmd.scan_step)
        begin
            scan_ptr_next = wrap_inc(scan_ptr_reg);
            scan_cnt_next = scan_cnt_reg + OCC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            occ_reg       <= '0;
            scan_ptr_reg  <= '0;
            scan_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            occ_reg      <= occ_next;
            scan_ptr_reg <= scan_ptr_next;
            scan_cnt_reg <= scan_cnt_next;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // store write and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
            mem[tail_reg] <= value;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    // output payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_status_reg <= cmd.out_status;
            out_data_reg   <= cmd.out_use_mem ? rd_data_reg : '0;
            out_last_reg   <= cmd.out_last;
        end
    end

    assign sts.empty      = (occ_reg == '0);
    assign sts.full       = (occ_reg == OCC_MAX);
    assign sts.last_entry = (scan_cnt_reg + OCC_W'(1) == occ_reg);
    assign sts.out_valid  = out_valid_reg;

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign data      = out_data_reg;
    assign last      = out_last_reg;

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_MAX)
        else $error("occupancy above depth");

    a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_en |-> !sts.full)
        else $error("write into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> !sts.empty)
        else $error("pop from empty queue");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        sts.empty |-> (head_reg == tail_reg))
        else $error("empty queue with head and tail apart");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || !out_stall))
        else $error("output register overwritten while held");

endmodule

### hw/rtl/cfq_ctrl.sv
// Controller: accepts transactions and sequences store reads for remove and display.
`timescale 1ns / 1ps

module cfq_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [cfq_pkg::OP_W-1:0]      operation,
    input  logic                          out_stall,
    input  cfq_pkg::cfq_sts_t             sts,
    output logic                          in_stall,
    output cfq_pkg::cfq_cmd_t             cmd
);

    typedef enum logic {
        S_IDLE,
        S_READ
    } state_t;

    state_t                      state_reg, state_next;
    logic [cfq_pkg::OP_W-1:0]    op_reg, op_next;
    logic                        out_free;

    assign out_free = !sts.out_valid || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        in_stall   = 1'b1;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = !out_free;
                if (in_valid && out_free)
                begin
                    op_next = operation;
                    cmd.out_last = 1'b1;
                    priority case (operation)
                        cfq_pkg::OP_INSERT:
                        begin
                            cmd.out_load = 1'b1;
                            if (sts.full)
                                cmd.out_status = cfq_pkg::ST_OVERFLOW;
                            else
                            begin
                                cmd.wr_en      = 1'b1;
                                cmd.out_status = cfq_pkg::ST_OK;
                            end
                        end
                        cfq_pkg::OP_REMOVE:
                        begin
                            if (sts.empty)
                            begin
                                cmd.out_load   = 1'b1;
                                cmd.out_status = cfq_pkg::ST_UNDERFLOW;
                            end
                            else
                            begin
                                cmd.scan_start = 1'b1;
                                state_next     = S_READ;
                            end
                        end
                        cfq_pkg::OP_DISPLAY:
                        begin
                            if (sts.empty)
                            begin
                                cmd.out_load   = 1'b1;
                                cmd.out_status = cfq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                cmd.scan_start = 1'b1;
                                state_next     = S_READ;
                            end
                        end
                        default: ;  // unused code: dropped
                    endcase
                end
            end
            S_READ:
            begin
                if (out_free)
                begin
                    cmd.out_load    = 1'b1;
                    cmd.out_use_mem = 1'b1;
                    cmd.out_status  = cfq_pkg::ST_OK;
                    if (op_reg == cfq_pkg::OP_REMOVE)
                    begin
                        cmd.pop      = 1'b1;
                        cmd.out_last = 1'b1;
                        state_next   = S_IDLE;
                    end
                    else if (sts.last_entry)
                    begin
                        cmd.out_last = 1'b1;
                        state_next   = S_IDLE;
                    end
                    else
                        cmd.scan_step = 1'b1;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= cfq_pkg::OP_INSERT;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

endmodule

### hw/rtl/circular_fifo_queue_unit.sv
// Top level of the circular FIFO queue of signed 32-bit words.
`timescale 1ns / 1ps
//
// Usage:
//   Input channel (in_valid/in_stall, operation, value) takes one transaction
//   per command: insert, remove or display. Output channel (out_valid/out_stall,
//   status, data, last) returns the results; last marks the final result of a
//   command. A transaction moves on a rising edge with valid high, stall low.
// Result sequencing:
//   Insert, overflow, underflow and empty display: result in the cycle after
//   acceptance; one command per cycle while the receiver keeps up.
//   Remove and display of N held words: each word passes the registered
//   store read, then the output register, one word per cycle while the
//   receiver keeps up; no new command is taken until the last word is
//   loaded. The store has a single registered read port.
//   Operation code 3 is dropped without a result.
// Reset: rst_n clears the pointers, occupancy and output valid; the queue is
//   empty and ready at once. Store contents are not cleared.
// Stall: a result waits in the output register while out_stall is high; the
//   unit holds off new commands and display scans until the register frees.
//
module circular_fifo_queue_unit #(
    parameter int DEPTH = cfq_pkg::DEPTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // command channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [cfq_pkg::OP_W-1:0]            operation,
    input  logic signed [cfq_pkg::WORD_W-1:0]   value,
    // result channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [cfq_pkg::STATUS_W-1:0]        status,
    output logic signed [cfq_pkg::WORD_W-1:0]   data,
    output logic                                last
);

    cfq_pkg::cfq_cmd_t cmd;
    cfq_pkg::cfq_sts_t sts;

    // Controller decides each transaction's fate from occupancy flags.
    cfq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .operation (operation),
        .out_stall (out_stall),
        .sts       (sts),
        .in_stall  (in_stall),
        .cmd       (cmd)
    );

    // Datapath holds the ring store and the output register.
    cfq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .value     (value),
        .out_stall (out_stall),
        .sts       (sts),
        .out_valid (out_valid),
        .status    (status),
        .data      (data),
        .last      (last)
    );

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for circular_fifo_queue_unit: directed table, then random traffic.
module tb;

    localparam int DEPTH = cfq_pkg::DEPTH_DEFAULT;

    // Operation code 3 has no meaning in the unit; it must be dropped silently.
    localparam logic [cfq_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    // Cycles with no transaction on either channel before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 2000;

    // Quiet time after the last expected result: longer than a full display scan.
    localparam int SETTLE_CYCLES = 2 * DEPTH + 8;

    // Counted commands per random phase (unused codes are not counted).
    localparam int RANDOM_PER_PHASE = 103;

    // One result transaction, field for field as on the result channel.
    typedef struct packed {
        logic [cfq_pkg::STATUS_W-1:0]      status;
        logic signed [cfq_pkg::WORD_W-1:0] data;
        logic                              last;
    } result_t;

    // One row of the directed table. A pinned row carries its result typed in;
    // the others are checked against the queue predictor.
    typedef struct packed {
        logic [cfq_pkg::OP_W-1:0]          op;
        logic signed [cfq_pkg::WORD_W-1:0] word;
        logic                              pinned;
        result_t                           want;
    } row_t;

    localparam result_t R_OK        = '{cfq_pkg::ST_OK, 32'sd0, 1'b1};
    localparam result_t R_OVERFLOW  = '{cfq_pkg::ST_OVERFLOW, 32'sd0, 1'b1};
    localparam result_t R_UNDERFLOW = '{cfq_pkg::ST_UNDERFLOW, 32'sd0, 1'b1};
    localparam result_t R_EMPTY     = '{cfq_pkg::ST_EMPTY, 32'sd0, 1'b1};
    localparam result_t R_NONE      = '0;

    // Directed part. The queue starts empty, fills to the brim with the word
    // extremes, overflows, is shown while full with the tail wrapped, and
    // drains part way. Remove and display carry junk in value to prove it is
    // ignored.
    localparam int DIRECTED_ROWS = 23;
    row_t directed_rows [DIRECTED_ROWS] = '{
        '{cfq_pkg::OP_DISPLAY, 32'sd0,         1'b1, R_EMPTY},      // show while empty
        '{cfq_pkg::OP_REMOVE,  32'sh7fff_ffff, 1'b1, R_UNDERFLOW},  // take from empty
        '{OP_UNUSED,           32'sh1234_5678, 1'b0, R_NONE},       // dropped, no result
        '{cfq_pkg::OP_INSERT,  32'sh8000_0000, 1'b1, R_OK},         // most negative word
        '{cfq_pkg::OP_INSERT,  32'sh7fff_ffff, 1'b1, R_OK},         // most positive word
        '{cfq_pkg::OP_INSERT,  32'sd0,         1'b1, R_OK},
        '{cfq_pkg::OP_INSERT,  -32'sd1,        1'b1, R_OK},
        '{cfq_pkg::OP_DISPLAY, 32'sh5a5a_5a5a, 1'b0, R_NONE},       // four words
        '{cfq_pkg::OP_REMOVE,  -32'sd1,        1'b1,
          '{cfq_pkg::ST_OK, 32'sh8000_0000, 1'b1}},
        '{cfq_pkg::OP_INSERT,  32'sh5555_5555, 1'b1, R_OK},
        '{cfq_pkg::OP_INSERT,  32'shaaaa_aaaa, 1'b1, R_OK},
        '{cfq_pkg::OP_INSERT,  32'sd1,         1'b1, R_OK},
        '{cfq_pkg::OP_INSERT,  32'sd2,         1'b1, R_OK},         // tail wraps here
        '{cfq_pkg::OP_INSERT,  32'sd3,         1'b1, R_OK},         // now full
        '{cfq_pkg::OP_INSERT,  32'sh0bad_f00d, 1'b1, R_OVERFLOW},   // rejected, no change
        '{OP_UNUSED,           -32'sd1,        1'b0, R_NONE},       // dropped while full
        '{cfq_pkg::OP_DISPLAY, 32'sh0000_ffff, 1'b0, R_NONE},       // eight words, wraps
        '{cfq_pkg::OP_REMOVE,  32'sd0,         1'b1,
          '{cfq_pkg::ST_OK, 32'sh7fff_ffff, 1'b1}},
        '{cfq_pkg::OP_REMOVE,  32'sd0,         1'b1, '{cfq_pkg::ST_OK, 32'sd0, 1'b1}},
        '{cfq_pkg::OP_REMOVE,  32'sd0,         1'b1, '{cfq_pkg::ST_OK, -32'sd1, 1'b1}},
        '{cfq_pkg::OP_REMOVE,  32'sh8000_0000, 1'b0, R_NONE},       // head wraps soon
        '{cfq_pkg::OP_DISPLAY, 32'sd0,         1'b0, R_NONE},
        '{cfq_pkg::OP_REMOVE,  32'sd0,         1'b0, R_NONE}
    };

    // Clock, reset and the two channels. Every input is known from time zero.
    logic                              clk;
    logic                              rst_n     = 1'b0;
    logic                              in_valid  = 1'b0;
    logic                              in_stall;
    logic [cfq_pkg::OP_W-1:0]          operation = cfq_pkg::OP_INSERT;
    logic signed [cfq_pkg::WORD_W-1:0] value     = '0;
    logic                              out_valid;
    logic                              out_stall = 1'b0;
    logic [cfq_pkg::STATUS_W-1:0]      status;
    logic signed [cfq_pkg::WORD_W-1:0] data;
    logic                              last;

    // Typed-in expectation, driven alongside the command payload so that the
    // monitor picks up the one that belongs to the accepted transaction.
    logic                     pin_valid  = 1'b0;
    result_t                  pin_result = '0;

    // Idling knobs, in percent per cycle.
    int idle_pct  = 0;
    int stall_pct = 0;

    // Predictor state: its own copy of the ring and its pointers.
    logic signed [cfq_pkg::WORD_W-1:0] ring_words [DEPTH];
    int                                ring_head  = 0;
    int                                ring_tail  = 0;
    int                                ring_count = 0;
    result_t                           predicted_batch [DEPTH];

    // Results still owed by the unit, oldest first.
    result_t awaited_results [$];

    int fail_count      = 0;
    int quiet_cycles    = 0;
    int results_checked = 0;
    int inserts_seen    = 0;
    int removes_seen    = 0;
    int displays_seen   = 0;
    int unused_seen     = 0;
    int overflows_seen  = 0;
    int underflows_seen = 0;
    int empties_seen    = 0;

    circular_fifo_queue_unit #(
        .DEPTH(DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .operation(operation),
        .value    (value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status   (status),
        .data     (data),
        .last     (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Applies one accepted command to the predictor's ring and fills
    // predicted_batch with the results it must cause. Returns how many.
    function automatic int predict_queue_results(
        input logic [cfq_pkg::OP_W-1:0]          op,
        input logic signed [cfq_pkg::WORD_W-1:0] word);
        int n;
        int slot;
        n = 0;
        slot = ring_head;
        case (op)
            cfq_pkg::OP_INSERT:
            begin
                inserts_seen++;
                if (ring_count == DEPTH)
                begin
                    predicted_batch[0] = R_OVERFLOW;
                    overflows_seen++;
                end
                else
                begin
                    ring_words[ring_tail] = word;
                    ring_tail = (ring_tail + 1) % DEPTH;
                    ring_count++;
                    predicted_batch[0] = R_OK;
                end
                n = 1;
            end
            cfq_pkg::OP_REMOVE:
            begin
                removes_seen++;
                if (ring_count == 0)
                begin
                    predicted_batch[0] = R_UNDERFLOW;
                    underflows_seen++;
                end
                else
                begin
                    predicted_batch[0] = '{cfq_pkg::ST_OK, ring_words[ring_head], 1'b1};
                    ring_head = (ring_head + 1) % DEPTH;
                    ring_count--;
                end
                n = 1;
            end
            cfq_pkg::OP_DISPLAY:
            begin
                displays_seen++;
                if (ring_count == 0)
                begin
                    predicted_batch[0] = R_EMPTY;
                    empties_seen++;
                    n = 1;
                end
                else
                begin
                    // Oldest first; only the newest word closes the run.
                    for (n = 0; n < ring_count; n++)
                    begin
                        predicted_batch[n] = '{cfq_pkg::ST_OK, ring_words[slot],
                                               n == ring_count - 1};
                        slot = (slot + 1) % DEPTH;
                    end
                end
            end
            default:
                unused_seen++;
        endcase
        return n;
    endfunction

    // Monitor on both channels: predicts on every accepted command transaction,
    // checks every accepted result transaction, drives the receiver's stall and
    // watches for a hang. All channel signals are sampled before this edge's
    // updates land, so the order of processes within the time step is moot.
    always @(posedge clk)
    begin : channel_monitor
        result_t got;
        result_t want;
        int      n;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                n = predict_queue_results(operation, value);
                if (pin_valid)
                    awaited_results.push_back(pin_result);
                else
                    for (int i = 0; i < n; i++)
                        awaited_results.push_back(predicted_batch[i]);
            end

            if (out_valid && !out_stall)
            begin
                got = '{status, data, last};
                results_checked++;
                if (awaited_results.size() == 0)
                begin
                    $error("unexpected result: status %0d data %h last %0d",
                           got.status, got.data, got.last);
                    fail_count++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (got.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        fail_count++;
                    end
                    if (got.data !== want.data)
                    begin
                        $error("data: expected %h, got %h", want.data, got.data);
                        fail_count++;
                    end
                    if (got.last !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, got.last);
                        fail_count++;
                    end
                end
            end

            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("watchdog: no transaction for %0d cycles, %0d results owed",
                             quiet_cycles, awaited_results.size());
                    $display("tb NOT OK");
                    $finish;
                end
            end

            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Presents one command and holds it, unchanged, until the unit takes it.
    // Afterwards the sender may go idle for a few cycles.
    task automatic issue_command(input logic [cfq_pkg::OP_W-1:0]          op,
                                 input logic signed [cfq_pkg::WORD_W-1:0] word,
                                 input logic                              pinned,
                                 input result_t                           want);
        operation  <= op;
        value      <= word;
        pin_valid  <= pinned;
        pin_result <= want;
        in_valid   <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Sender pauses until every owed result has come back, then lets the unit
    // sit a while so that a stray result would still be caught.
    task automatic wait_until_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : stimulus
        logic [cfq_pkg::OP_W-1:0]          op;
        logic signed [cfq_pkg::WORD_W-1:0] word;
        int                                roll;
        int                                counted;
        int                                bias_left;
        bit                                filling;

        bias_left = 0;
        filling   = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table under the first idling setting.
        idle_pct  = 6;
        stall_pct = 63;
        foreach (directed_rows[i])
            issue_command(directed_rows[i].op, directed_rows[i].word,
                          directed_rows[i].pinned, directed_rows[i].want);

        // Random traffic in three idling phases: sender mostly busy with a slow
        // receiver, then the reverse, then both flat out.
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    idle_pct  = 6;
                    stall_pct = 63;
                end
                1:
                begin
                    idle_pct  = 63;
                    stall_pct = 6;
                end
                default:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
            endcase

            counted = 0;
            while (counted < RANDOM_PER_PHASE)
            begin
                // Alternate fill and drain bursts so the queue keeps hitting
                // full and empty, and the pointers wrap many times.
                if (bias_left == 0)
                begin
                    filling   = !filling;
                    bias_left = $urandom_range(8, 24);
                end
                bias_left--;

                roll = $urandom_range(99);
                if (roll < 3)
                    op = OP_UNUSED;
                else if (roll < 18)
                    op = cfq_pkg::OP_DISPLAY;
                else if (roll < (filling ? 75 : 45))
                    op = cfq_pkg::OP_INSERT;
                else
                    op = cfq_pkg::OP_REMOVE;

                case ($urandom_range(7))
                    0:       word = 32'sh8000_0000;
                    1:       word = 32'sh7fff_ffff;
                    2:       word = 32'sd0;
                    3:       word = -32'sd1;
                    4:       word = $urandom_range(255);
                    default: word = $urandom;
                endcase

                issue_command(op, word, 1'b0, R_NONE);
                if (op != OP_UNUSED)
                    counted++;
            end

            // Full pause between phases: nothing in flight when idling changes.
            wait_until_drained();
        end

        $display("Covered %0d inserts, %0d removes, %0d displays, %0d unused codes; %0d results",
                 inserts_seen, removes_seen, displays_seen, unused_seen, results_checked);
        $display("Corner hits: %0d overflows, %0d underflows, %0d empty displays",
                 overflows_seen, underflows_seen, empties_seen);
        if (fail_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/cfq_pkg.sv
hw/rtl/cfq_datapath.sv
hw/rtl/cfq_ctrl.sv
hw/rtl/circular_fifo_queue_unit.sv
test/tb.sv
